FILE: src/rc4_stream_cipher_core_assert.svh
// ----------------------------------------------------------------------------
// RC4 stream cipher core assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_STREAM_CIPHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SboxDepth = 256;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned KeyBytes  = 16;
  localparam int unsigned KeyIdxW   = 4;
  localparam int unsigned CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StFill = 10'b00_0000_0010,
    StKsRd = 10'b00_0000_0100,
    StKsJ  = 10'b00_0000_1000,
    StKsWj = 10'b00_0001_0000,
    StKsWs = 10'b00_0010_0000,
    StPrRd = 10'b00_0100_0000,
    StPrJ  = 10'b00_1000_0000,
    StPrT  = 10'b01_0000_0000,
    StPrOut = 10'b10_0000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic fill;
    logic ks_rd;
    logic ks_j;
    logic ks_wj;
    logic ks_ws;
    logic pr_rd;
    logic pr_j;
    logic pr_t;
    logic pr_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ctr_last;
    logic last_flag;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences S-box fill, key schedule and keystream generation per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   in_msg_q, in_msg_d;

  // Next state and command decode.
  always_comb begin
    state_d  = state_q;
    in_msg_d = in_msg_q;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = in_msg_q ? StPrRd : StFill;
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (sts_i.ctr_last) begin
          in_msg_d = 1'b1;
          state_d  = StKsRd;
        end
      end
      StKsRd: begin
        cmd_o.ks_rd = 1'b1;
        state_d = StKsJ;
      end
      StKsJ: begin
        cmd_o.ks_j = 1'b1;
        state_d = StKsWj;
      end
      StKsWj: begin
        cmd_o.ks_wj = 1'b1;
        state_d = StKsWs;
      end
      StKsWs: begin
        cmd_o.ks_ws = 1'b1;
        state_d = sts_i.ctr_last ? StPrRd : StKsRd;
      end
      StPrRd: begin
        cmd_o.pr_rd = 1'b1;
        state_d = StPrJ;
      end
      StPrJ: begin
        cmd_o.pr_j = 1'b1;
        state_d = StPrT;
      end
      StPrT: begin
        cmd_o.pr_t = 1'b1;
        state_d = StPrOut;
      end
      StPrOut: begin
        // Wait for room in the output register.
        if (sts_i.out_free) begin
          cmd_o.pr_out = 1'b1;
          if (sts_i.last_flag) begin
            in_msg_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      in_msg_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_msg_q <= in_msg_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rc4_dp.sv
// ----------------------------------------------------------------------------
// RC4 datapath
// Key registers, S-box memory, indexes and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_dp
  import rc4_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [KeyW-1:0]    cfg_data_i,
  input  wire logic [ByteW-1:0]   in_data_i,
  input  wire logic               in_last_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [ByteW-1:0]        out_data_o,
  output logic                    out_last_o
);

  logic [KeyW-1:0]    key_low_q, key_high_q;
  logic [2*KeyW-1:0]  key_all;
  logic [ByteW-1:0]   key_byte;

  logic [ByteW-1:0]   sbox_mem [SboxDepth];
  logic [ByteW-1:0]   rd_a_q, rd_b_q;
  logic               re_a, re_b, we;
  logic [ByteW-1:0]   ra_a, ra_b, wa, wd;

  logic [ByteW-1:0]   ctr_q, i_q, j_q;
  logic [KeyIdxW-1:0] kc_q;
  logic [ByteW-1:0]   si_q, sj_q, bypv_q;
  logic               byp_q;
  logic [ByteW-1:0]   data_q;
  logic               last_q;
  logic [ByteW-1:0]   out_q;
  logic               out_last_q, out_valid_q;

  logic [ByteW-1:0]   j_new, t_idx, ks_val;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegKeyHigh: key_high_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Key byte for the current schedule step.
  assign key_all  = {key_high_q, key_low_q};
  assign key_byte = key_all[{kc_q, 3'b000} +: ByteW];

  // New j during the key schedule or keystream generation.
  assign j_new = j_q + rd_a_q + (cmd_i.ks_j ? key_byte : '0);
  // Keystream index from the swapped pair.
  assign t_idx = si_q + rd_b_q;
  assign ks_val = byp_q ? bypv_q : rd_a_q;

  // Memory port selection.
  always_comb begin
    re_a = 1'b0;
    ra_a = ctr_q;
    re_b = cmd_i.ks_j | cmd_i.pr_j;
    ra_b = j_new;
    we   = 1'b0;
    wa   = ctr_q;
    wd   = ctr_q;
    if (cmd_i.ks_rd) begin
      re_a = 1'b1;
    end else if (cmd_i.pr_rd) begin
      re_a = 1'b1;
      ra_a = i_q + 8'd1;
    end else if (cmd_i.pr_t) begin
      re_a = 1'b1;
      ra_a = t_idx;
    end
    if (cmd_i.fill) begin
      we = 1'b1;
    end else if (cmd_i.ks_wj || cmd_i.pr_t) begin
      we = 1'b1;
      wa = j_q;
      wd = si_q;
    end else if (cmd_i.ks_ws) begin
      we = 1'b1;
      wd = sj_q;
    end else if (cmd_i.pr_out) begin
      we = 1'b1;
      wa = i_q;
      wd = sj_q;
    end
  end

  // S-box memory with registered reads.
  always_ff @(posedge clk_i) begin
    if (we) begin
      sbox_mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_q <= sbox_mem[ra_a];
    end
    if (re_b) begin
      rd_b_q <= sbox_mem[ra_b];
    end
  end

  // Counters and indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      kc_q  <= '0;
      i_q   <= '0;
      j_q   <= '0;
    end else begin
      if (cmd_i.load_in) begin
        ctr_q <= '0;
      end
      if (cmd_i.fill) begin
        ctr_q <= ctr_q + 8'd1;
        j_q   <= '0;
        kc_q  <= '0;
      end
      if (cmd_i.ks_j) begin
        j_q  <= j_new;
        kc_q <= (kc_q == KeyIdxW'(KeyBytes - 1)) ? '0 : kc_q + 1'b1;
      end
      if (cmd_i.ks_ws) begin
        ctr_q <= ctr_q + 8'd1;
        if (sts_o.ctr_last) begin
          i_q <= '0;
          j_q <= '0;
        end
      end
      if (cmd_i.pr_rd) begin
        i_q <= i_q + 8'd1;
      end
      if (cmd_i.pr_j) begin
        j_q <= j_new;
      end
    end
  end

  // Swap operands, keystream bypass and input word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
    if (cmd_i.ks_j || cmd_i.pr_j) begin
      si_q <= rd_a_q;
    end
    if (cmd_i.ks_wj || cmd_i.pr_t) begin
      sj_q <= rd_b_q;
    end
    // The read of S[t] sees the table before the swap lands, so patch it.
    if (cmd_i.pr_t) begin
      if (t_idx == i_q) begin
        byp_q  <= 1'b1;
        bypv_q <= rd_b_q;
      end else if (t_idx == j_q) begin
        byp_q  <= 1'b1;
        bypv_q <= si_q;
      end else begin
        byp_q  <= 1'b0;
        bypv_q <= si_q;
      end
    end
    if (cmd_i.pr_out) begin
      out_q      <= data_q ^ ks_val;
      out_last_q <= last_q;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pr_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.ctr_last  = (ctr_q == 8'hFF);
  assign sts_o.last_flag = last_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: src/rc4_stream_cipher_core.sv
// An accepted word passes the read, j, t and output states in turn, its result
// registered once the output register has room; the first word of a message is
// preceded by the S-box fill and key schedule. No new word is taken until the
// last result is written, set by the single S-box write port and registered reads.
// Reset clears keys, indexes and control; the S-box is rebuilt per message.
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Encrypts or decrypts a byte stream with RC4, rekeying at each message start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core
  import rc4_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [KeyW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic               s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [ByteW-1:0]        m_axis_tdata,   // [7:0] out_byte
  output logic                    m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath and S-box memory.
  rc4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`include "rc4_stream_cipher_core_assert.svh"

  // A result is only written when the output register can take it.
  `RC4_ASSERT_SAME(a_out_room, cmd.pr_out, !m_axis_tvalid || m_axis_tready, "result overwrote a pending word")
  // The key schedule hands over straight to keystream generation.
  `RC4_ASSERT_NEXT(a_ks_done, cmd.ks_ws && sts.ctr_last, cmd.pr_rd, "key schedule did not hand over")
  // Once a result is written it is presented, and the input is open again.
  `RC4_ASSERT_NEXT(a_out_follow, cmd.pr_out, m_axis_tvalid && s_axis_tready, "result word not presented")

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Streams byte messages through the core under several keys and compares
// every output word with an RC4 keystream computed alongside, including key
// updates in the middle of a message, one-byte messages and long messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rc4_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned TargetWords   = 1500;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cipher_word_t;

  // Scoreboard holding its own copy of the cipher state and the key registers.
  class cipher_scoreboard;
    logic [ByteW-1:0] sbox [SboxDepth];
    logic [ByteW-1:0] idx_i;
    logic [ByteW-1:0] idx_j;
    logic             in_message;
    logic [KeyW-1:0]  key_low;
    logic [KeyW-1:0]  key_high;
    cipher_word_t     expected_words [$];
    int unsigned      errors;

    function new();
      key_low    = '0;
      key_high   = '0;
      idx_i      = '0;
      idx_j      = '0;
      in_message = 1'b0;
      errors     = 0;
    endfunction

    function void write_key(logic [CfgIdxW-1:0] idx, logic [KeyW-1:0] value);
      case (idx)
        RegKeyLow:  key_low  = value;
        RegKeyHigh: key_high = value;
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] key_byte(int unsigned k);
      if (k < 8) return key_low[8*k +: 8];
      return key_high[8*(k-8) +: 8];
    endfunction

    // Identity permutation followed by the 256-step key schedule.
    function void rekey();
      logic [ByteW-1:0] j;
      logic [ByteW-1:0] tmp;
      j = '0;
      for (int s = 0; s < SboxDepth; s++) sbox[s] = ByteW'(s);
      for (int s = 0; s < SboxDepth; s++) begin
        j       = j + sbox[s] + key_byte(s % KeyBytes);
        tmp     = sbox[s];
        sbox[s] = sbox[j];
        sbox[j] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    // Advances the keystream by one byte and queues the expected output word.
    function void note_plain_word(logic [ByteW-1:0] data, logic last);
      logic [ByteW-1:0] tmp;
      logic [ByteW-1:0] t;
      cipher_word_t     w;
      if (!in_message) begin
        rekey();
        in_message = 1'b1;
      end
      idx_i       = idx_i + 1'b1;
      idx_j       = idx_j + sbox[idx_i];
      tmp         = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = tmp;
      t           = sbox[idx_i] + sbox[idx_j];
      w.data      = data ^ sbox[t];
      w.last      = last;
      expected_words.push_back(w);
      if (last) in_message = 1'b0;
    endfunction

    function void check_cipher_word(logic [ByteW-1:0] data, logic last);
      cipher_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual out_byte %02h out_last %0b",
                 $time, data, last);
        return;
      end
      w = expected_words.pop_front();
      if (data !== w.data) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, w.data, data);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: out_last mismatch: expected %0b, actual %0b", $time, w.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [KeyW-1:0]    cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata;   // [7:0] data_byte
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;   // [7:0] out_byte
  logic               m_axis_tlast;

  cipher_scoreboard sb;
  int unsigned      words_sent;
  int unsigned      burst_left;
  int unsigned      msg_left;
  int unsigned      idle_cycles = 0;
  logic [15:0]      stall_pattern;
  logic [5:0]       pattern_age = '0;

  rc4_stream_cipher_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one word, waits for its acceptance, then perhaps pauses between bursts.
  task automatic send_word(input logic [ByteW-1:0] data, input logic last);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_plain_word(data, last);
    words_sent++;
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Random message content; a phase may end part-way through a message.
  task automatic send_stream(input int unsigned count);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      if (msg_left == 0) begin
        r = $urandom_range(0, 15);
        if (r < 2)       msg_left = 1;
        else if (r == 2) msg_left = $urandom_range(200, 300);
        else             msg_left = $urandom_range(2, 24);
      end
      send_word(ByteW'($urandom_range(0, 255)), msg_left == 1);
      msg_left--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every expected word has come out.
  task automatic drain();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_key(idx, value);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Stimulus: directed messages first, then random phases with key updates.
  initial begin
    sb            = new();
    words_sent    = 0;
    burst_left    = 0;
    msg_left      = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegKeyLow;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte message under the all-zero reset key.
    send_word(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;
    drain();

    // All-ones key, then a key update in the middle of the message.
    write_key_reg(RegKeyLow, '1);
    write_key_reg(RegKeyHigh, '1);
    cfg_we_i <= 1'b0;
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'ha5, 1'b0);
    send_word(8'h5a, 1'b0);
    s_axis_tvalid <= 1'b0;
    drain();
    write_key_reg(RegKeyLow, 64'h0123_4567_89ab_cdef);
    cfg_we_i <= 1'b0;
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
    // The next message picks up the new low key.
    send_word(8'hff, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;
    drain();
    write_key_reg(RegKeyHigh, '0);
    cfg_we_i <= 1'b0;
    send_word(8'hff, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (words_sent < TargetWords) begin
      drain();
      case ($urandom_range(0, 3))
        1: write_key_reg(RegKeyLow, pick_key());
        2: write_key_reg(RegKeyHigh, pick_key());
        3: begin
          write_key_reg(RegKeyLow, pick_key());
          write_key_reg(RegKeyHigh, pick_key());
        end
        default: ;
      endcase
      cfg_we_i <= 1'b0;
      send_stream($urandom_range(1, 40));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver back-pressure: a rotating pattern, replaced when the 6-bit age counter wraps.
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;
        1:       stall_pattern = 16'($urandom);
        2:       stall_pattern = 16'($urandom) & 16'($urandom);
        default: stall_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end
    m_axis_tready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    pattern_age   = pattern_age + 1'b1;
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_cipher_word(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+src
src/rc4_pkg.sv
src/rc4_ctrl.sv
src/rc4_dp.sv
src/rc4_stream_cipher_core.sv
bench/tb.sv
